[src/kpcs_pkg.sv]
// Shared constants, codes and types for the k-means partial centroid sum block.
package kpcs_pkg;

    localparam int MAX_CLUSTERS = 16;
    localparam int MAX_COLUMNS  = 64;
    localparam int MAX_PARTS    = 8;
    localparam int SUM_WIDTH    = 48;

    localparam int CL_W        = $clog2(MAX_CLUSTERS);
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int PART_W      = $clog2(MAX_PARTS);
    localparam int ADDR_W      = PART_W + CL_W + COL_W;
    localparam int STORE_DEPTH = MAX_PARTS * MAX_CLUSTERS * MAX_COLUMNS;
    localparam int CLR_W       = $clog2(STORE_DEPTH + 1);

    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 3;
    localparam int OP_W       = 2;
    localparam int CFG_CL_W   = 5;
    localparam int CFG_COL_W  = 7;
    localparam int CFG_PART_W = 4;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_CLUSTERS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PARTS    = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_ACCUM     = 2'd0,
        OP_READ      = 2'd1,
        OP_READ_ZERO = 2'd2,
        OP_READ_ALT  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_BAD_LABEL  = 3'd1,
        ST_BAD_COLUMN = 3'd2,
        ST_BAD_PART   = 3'd3,
        ST_SATURATED  = 3'd4
    } status_t;

    // Checked request on its way to the update stage.
    typedef struct packed {
        op_t                op;
        logic [ADDR_W-1:0]  addr;
        status_t            status;
        logic [VALUE_W-1:0] value;
    } req_t;

    // Write-back to the accumulator store.
    typedef struct packed {
        logic                 en;
        logic [ADDR_W-1:0]    addr;
        logic [SUM_WIDTH-1:0] data;
    } wr_t;

endpackage

[src/kpcs_ctrl.sv]
// Configuration registers, range checks, part rotation and address forming.
module kpcs_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [kpcs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kpcs_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                accept,
    input  logic [kpcs_pkg::OP_W-1:0]           operation,
    input  logic [kpcs_pkg::CL_W-1:0]           cluster_label,
    input  logic [kpcs_pkg::COL_W-1:0]          column_index,
    input  logic [kpcs_pkg::PART_W-1:0]         part_select,
    input  logic [kpcs_pkg::VALUE_W-1:0]        sample_value,
    input  logic                                row_end,
    output kpcs_pkg::req_t                      req
);
    import kpcs_pkg::*;

    logic [CFG_CL_W-1:0]   clusters_in_use_reg;
    logic [CFG_COL_W-1:0]  columns_in_use_reg;
    logic [CFG_PART_W-1:0] parts_in_use_reg;
    logic [PART_W-1:0]     current_part_reg;
    logic [PART_W-1:0]     current_part_next;

    logic [CFG_CL_W-1:0]   ncl;
    logic [CFG_COL_W-1:0]  ncol;
    logic [CFG_PART_W-1:0] npart;
    logic [CFG_PART_W-1:0] nxt;
    logic [PART_W-1:0]     part;
    op_t                   op_in;
    status_t               st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clusters_in_use_reg <= CFG_CL_W'(MAX_CLUSTERS);
            columns_in_use_reg  <= CFG_COL_W'(MAX_COLUMNS);
            parts_in_use_reg    <= CFG_PART_W'(MAX_PARTS);
            current_part_reg    <= '0;
        end
        else
        begin
            current_part_reg <= current_part_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_CLUSTERS: clusters_in_use_reg <= cfg_data[CFG_CL_W-1:0];
                    REG_COLUMNS:  columns_in_use_reg  <= cfg_data[CFG_COL_W-1:0];
                    REG_PARTS:    parts_in_use_reg    <= cfg_data[CFG_PART_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    always_comb
    begin
        ncl   = (clusters_in_use_reg > CFG_CL_W'(MAX_CLUSTERS))
                ? CFG_CL_W'(MAX_CLUSTERS) : clusters_in_use_reg;
        ncol  = (columns_in_use_reg > CFG_COL_W'(MAX_COLUMNS))
                ? CFG_COL_W'(MAX_COLUMNS) : columns_in_use_reg;
        npart = (parts_in_use_reg > CFG_PART_W'(MAX_PARTS))
                ? CFG_PART_W'(MAX_PARTS) : parts_in_use_reg;

        op_in = op_t'(operation);
        part  = (op_in == OP_ACCUM) ? current_part_reg : part_select;

        // Label first, then column, then part: the first failure wins.
        if (CFG_CL_W'(cluster_label) >= ncl)
            st = ST_BAD_LABEL;
        else if (CFG_COL_W'(column_index) >= ncol)
            st = ST_BAD_COLUMN;
        else if (CFG_PART_W'(part) >= npart)
            st = ST_BAD_PART;
        else
            st = ST_OK;

        req.op     = op_in;
        req.addr   = {part, cluster_label, column_index};
        req.status = st;
        req.value  = sample_value;

        nxt = CFG_PART_W'(current_part_reg) + CFG_PART_W'(1);
        current_part_next = current_part_reg;
        if (accept && st == ST_OK && op_in == OP_ACCUM && row_end)
            current_part_next = (nxt >= npart) ? '0 : nxt[PART_W-1:0];
    end

endmodule

[src/kpcs_store.sv]
// Accumulator memory with registered read and the clearing pass after reset.
module kpcs_store (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                rd_en,
    input  logic [kpcs_pkg::ADDR_W-1:0]         rd_addr,
    output logic [kpcs_pkg::SUM_WIDTH-1:0]      rd_data,
    input  kpcs_pkg::wr_t                       wr,
    output logic                                clear_busy
);
    import kpcs_pkg::*;

    logic [SUM_WIDTH-1:0] sum_store_mem [STORE_DEPTH];
    logic [SUM_WIDTH-1:0] rd_data_reg;
    logic [CLR_W-1:0]     clr_cnt_reg;
    logic [CLR_W-1:0]     clr_cnt_next;

    assign clear_busy   = (clr_cnt_reg != CLR_W'(STORE_DEPTH));
    assign clr_cnt_next = clear_busy ? clr_cnt_reg + CLR_W'(1) : clr_cnt_reg;
    assign rd_data      = rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else
            clr_cnt_reg <= clr_cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (clear_busy)
            sum_store_mem[clr_cnt_reg[ADDR_W-1:0]] <= '0;
        else if (wr.en)
            sum_store_mem[wr.addr] <= wr.data;
        if (rd_en)
            rd_data_reg <= sum_store_mem[rd_addr];
    end

endmodule

[src/kpcs_update.sv]
// Read-modify-write stage: forwarding, saturating add, write-back and result register.
module kpcs_update (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  kpcs_pkg::req_t                      req,
    input  logic [kpcs_pkg::SUM_WIDTH-1:0]      rd_data,
    output kpcs_pkg::wr_t                       wr,
    output logic                                hold,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [kpcs_pkg::SUM_WIDTH-1:0] entry_sum,
    output logic [kpcs_pkg::STATUS_W-1:0]       status
);
    import kpcs_pkg::*;

    localparam logic [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    req_t                 s1_req_reg;
    logic                 fwd_valid_reg;
    logic [ADDR_W-1:0]    fwd_addr_reg;
    logic [SUM_WIDTH-1:0] fwd_data_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [SUM_WIDTH-1:0] out_sum_reg;
    status_t              out_status_reg;

    logic                 s1_go;
    logic [SUM_WIDTH-1:0] old;
    logic [SUM_WIDTH:0]   sum_wide;
    logic [SUM_WIDTH-1:0] acc;
    logic                 sat;
    logic [SUM_WIDTH-1:0] res_sum;
    status_t              res_status;

    assign s1_go = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign hold  = s1_valid_reg && !s1_go;

    always_comb
    begin
        // The last write-back landed after this entry was read, so it takes priority.
        old = (fwd_valid_reg && fwd_addr_reg == s1_req_reg.addr) ? fwd_data_reg : rd_data;
        sum_wide = {old[SUM_WIDTH-1], old}
                 + {{(SUM_WIDTH+1-VALUE_W){s1_req_reg.value[VALUE_W-1]}}, s1_req_reg.value};
        sat = (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]);
        if (sat)
            acc = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
        else
            acc = sum_wide[SUM_WIDTH-1:0];

        res_sum    = '0;
        res_status = s1_req_reg.status;
        wr.en      = 1'b0;
        wr.addr    = s1_req_reg.addr;
        wr.data    = '0;
        if (s1_req_reg.status == ST_OK)
        begin
            case (s1_req_reg.op)
                OP_ACCUM:
                begin
                    res_sum = acc;
                    if (sat)
                        res_status = ST_SATURATED;
                    wr.en   = s1_go;
                    wr.data = acc;
                end
                OP_READ_ZERO:
                begin
                    res_sum = old;
                    wr.en   = s1_go;
                end
                default:
                    res_sum = old;
            endcase
        end

        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_go)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (wr.en)
                fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_req_reg <= req;
        if (wr.en)
        begin
            fwd_addr_reg <= wr.addr;
            fwd_data_reg <= wr.data;
        end
        if (s1_go)
        begin
            out_sum_reg    <= res_sum;
            out_status_reg <= res_status;
        end
    end

    assign out_valid = out_valid_reg;
    assign entry_sum = out_sum_reg;
    assign status    = out_status_reg;

endmodule

[src/kmeans_partial_centroid_sums_top.sv]
// Top level of the k-means partial centroid sum accumulator.
// After reset the block sweeps its 8192-entry accumulator memory to zero, one entry a
// cycle, and holds in_stall high until the sweep is done; configuration writes are taken
// throughout. From then on it takes one request per cycle while the update stage is not
// held by out_stall: each request reads its entry from the single memory at the accepting
// edge; the read-modify-write stage then updates it, writes it back and loads the result
// register on one edge, as soon as the result register is free. A write-back register is
// forwarded to a request that follows on the same entry, so back-to-back updates of one
// entry run at full rate. One result register and one update stage buffer the output
// side: a new request is still taken while a finished result waits.
module kmeans_partial_centroid_sums_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [kpcs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [kpcs_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [kpcs_pkg::OP_W-1:0]             operation,
    input  logic [kpcs_pkg::CL_W-1:0]             cluster_label,
    input  logic [kpcs_pkg::COL_W-1:0]            column_index,
    input  logic [kpcs_pkg::PART_W-1:0]           part_select,
    input  logic signed [kpcs_pkg::VALUE_W-1:0]   sample_value,
    input  logic                                  row_end,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [kpcs_pkg::SUM_WIDTH-1:0] entry_sum,
    output logic [kpcs_pkg::STATUS_W-1:0]         status
);
    import kpcs_pkg::*;

    req_t                 req;
    wr_t                  wr;
    logic [SUM_WIDTH-1:0] rd_data;
    logic                 clear_busy;
    logic                 hold;
    logic                 accept;

    assign in_stall = clear_busy || hold;
    assign accept   = in_valid && !in_stall;

    kpcs_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .accept        (accept),
        .operation     (operation),
        .cluster_label (cluster_label),
        .column_index  (column_index),
        .part_select   (part_select),
        .sample_value  (sample_value),
        .row_end       (row_end),
        .req           (req)
    );

    kpcs_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (accept),
        .rd_addr    (req.addr),
        .rd_data    (rd_data),
        .wr         (wr),
        .clear_busy (clear_busy)
    );

    kpcs_update u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req       (req),
        .rd_data   (rd_data),
        .wr        (wr),
        .hold      (hold),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .entry_sum (entry_sum),
        .status    (status)
    );

`ifndef SYNTHESIS
    // No request may be taken while the memory is still being cleared.
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy |-> !accept)
        else $error("request accepted during clearing pass");

    // The update stage never writes while the clearing pass owns the write port.
    a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy |-> !wr.en)
        else $error("write-back during clearing pass");

    // A rejected request reports a zero sum.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK && status != ST_SATURATED) |-> (entry_sum == '0))
        else $error("rejected request returned a nonzero sum");
`endif

endmodule

[tb/kmeans_partial_centroid_sums_top_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the k-means partial centroid sum accumulator.
module kmeans_partial_centroid_sums_top_test;
    import kpcs_pkg::*;

    localparam int QUIET_LIMIT  = 40000;
    localparam int REPORT_LIMIT = 10;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 225;
    localparam int RAIL_ADDS    = 8;
    localparam int PHASE_IDLE [PHASES] = '{25, 40, 0, 10, 30, 0};
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam longint SUM_HI = (64'sd1 <<< (SUM_WIDTH - 1)) - 64'sd1;
    localparam longint SUM_LO = -SUM_HI - 64'sd1;

    typedef struct {
        logic signed [SUM_WIDTH-1:0] sum;
        status_t                     st;
    } sum_result_t;

    typedef enum logic {
        STEP_REQ,
        STEP_CFG
    } step_kind_t;

    typedef struct {
        step_kind_t                  kind;
        op_t                         op;
        logic [CL_W-1:0]             cl;
        logic [COL_W-1:0]            col;
        logic [PART_W-1:0]           psel;
        logic signed [VALUE_W-1:0]   value;
        logic                        last;
        logic                        known;
        logic signed [SUM_WIDTH-1:0] sum;
        status_t                     st;
        logic [CFG_IDX_W-1:0]        reg_idx;
        int                          reg_val;
    } plan_row_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [CFG_DATA_W-1:0]       cfg_data = '0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [OP_W-1:0]             operation = '0;
    logic [CL_W-1:0]             cluster_label = '0;
    logic [COL_W-1:0]            column_index = '0;
    logic [PART_W-1:0]           part_select = '0;
    logic signed [VALUE_W-1:0]   sample_value = '0;
    logic                        row_end = 1'b0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic signed [SUM_WIDTH-1:0] entry_sum;
    logic [STATUS_W-1:0]         status;

    // Predictor state and the register values it works from.
    logic signed [SUM_WIDTH-1:0] acc_store [STORE_DEPTH];
    int cfg_clusters = 16;
    int cfg_columns = 64;
    int cfg_parts = 8;
    int cur_part = 0;
    sum_result_t sum_expect_q [$];

    logic                        req_known = 1'b0;
    logic signed [SUM_WIDTH-1:0] req_sum = '0;
    status_t                     req_status = ST_OK;

    int idle_pct = 0;
    int stall_left = 0;
    int errors = 0;
    int quiet = 0;
    plan_row_t dir_plan [$];

    kmeans_partial_centroid_sums_top uut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int capped(int v, int top);
        return (v > top) ? top : v;
    endfunction

    function automatic sum_result_t centroid_predict(op_t op, logic [CL_W-1:0] cl,
            logic [COL_W-1:0] col, logic [PART_W-1:0] psel,
            logic signed [VALUE_W-1:0] value, logic last);
        sum_result_t r;
        int ncl;
        int ncol;
        int npart;
        int part;
        int addr;
        longint acc;
        longint inc;
        r.sum = '0;
        r.st = ST_OK;
        ncl = capped(cfg_clusters, MAX_CLUSTERS);
        ncol = capped(cfg_columns, MAX_COLUMNS);
        npart = capped(cfg_parts, MAX_PARTS);
        part = (op == OP_ACCUM) ? cur_part : int'(psel);
        if (int'(cl) >= ncl)
            r.st = ST_BAD_LABEL;
        else if (int'(col) >= ncol)
            r.st = ST_BAD_COLUMN;
        else if (part >= npart)
            r.st = ST_BAD_PART;
        if (r.st == ST_OK)
        begin
            addr = (part * MAX_CLUSTERS + int'(cl)) * MAX_COLUMNS + int'(col);
            if (op == OP_ACCUM)
            begin
                acc = longint'(acc_store[addr]);
                inc = longint'(value);
                if (inc > 0 && acc > SUM_HI - inc)
                begin
                    acc = SUM_HI;
                    r.st = ST_SATURATED;
                end
                else if (inc < 0 && acc < SUM_LO - inc)
                begin
                    acc = SUM_LO;
                    r.st = ST_SATURATED;
                end
                else
                    acc = acc + inc;
                acc_store[addr] = acc[SUM_WIDTH-1:0];
                r.sum = acc[SUM_WIDTH-1:0];
                // A saturated element still ends its row.
                if (last)
                    cur_part = (cur_part + 1 >= npart) ? 0 : cur_part + 1;
            end
            else
            begin
                r.sum = acc_store[addr];
                if (op == OP_READ_ZERO)
                    acc_store[addr] = '0;
            end
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        sum_result_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CLUSTERS: cfg_clusters = int'(cfg_data[CFG_CL_W-1:0]);
                    REG_COLUMNS:  cfg_columns = int'(cfg_data[CFG_COL_W-1:0]);
                    REG_PARTS:    cfg_parts = int'(cfg_data[CFG_PART_W-1:0]);
                    default:      ;
                endcase
            end
            quiet++;
            if (in_valid && !in_stall)
            begin
                want = centroid_predict(op_t'(operation), cluster_label, column_index,
                                        part_select, sample_value, row_end);
                if (req_known)
                begin
                    want.sum = req_sum;
                    want.st = req_status;
                end
                sum_expect_q.push_back(want);
                quiet = 0;
            end
            if (out_valid && !out_stall)
            begin
                quiet = 0;
                if (sum_expect_q.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("result with no request: sum %0d status %0d",
                                 entry_sum, status);
                end
                else
                begin
                    want = sum_expect_q.pop_front();
                    if (entry_sum !== want.sum || status !== want.st)
                    begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                            $display("mismatch: entry_sum exp %0d got %0d, status exp %0d got %0d",
                                     want.sum, entry_sum, want.st, status);
                    end
                end
            end
        end
        if (quiet >= QUIET_LIMIT)
        begin
            $display("kmeans_partial_centroid_sums_top_test: done, errors");
            $finish;
        end
    end

    // Output back-pressure comes in bursts whose rate follows the current phase.
    always @(negedge clk)
    begin
        if (stall_left == 0 && idle_pct != 0 && $urandom_range(99, 0) < idle_pct / 4)
            stall_left = $urandom_range(12, 1);
        out_stall = (stall_left != 0);
        if (stall_left != 0)
            stall_left--;
    end

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_request(op_t op, logic [CL_W-1:0] cl, logic [COL_W-1:0] col,
            logic [PART_W-1:0] psel, logic signed [VALUE_W-1:0] value, logic last);
        if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct / 2)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(12, 1)) @(negedge clk);
        end
        in_valid = 1'b1;
        operation = op;
        cluster_label = cl;
        column_index = col;
        part_select = psel;
        sample_value = value;
        row_end = last;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (sum_expect_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = CFG_DATA_W'(val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic program_regs(int ncl, int ncol, int npart);
        wait_drained();
        write_reg(REG_CLUSTERS, ncl);
        write_reg(REG_COLUMNS, ncol);
        write_reg(REG_PARTS, npart);
    endtask

    // Ends rows until the round robin is back at part zero, unless it is stuck.
    task automatic rewind_part();
        while (cur_part != 0 && cur_part < capped(cfg_parts, MAX_PARTS)
               && cfg_clusters != 0 && cfg_columns != 0)
            send_request(OP_ACCUM, '0, '0, '0, 32'sd1, 1'b1);
    endtask

    function automatic plan_row_t req_row(op_t op, int cl, int col, int psel, int value,
            bit last);
        plan_row_t r;
        r.kind = STEP_REQ;
        r.op = op;
        r.cl = CL_W'(cl);
        r.col = COL_W'(col);
        r.psel = PART_W'(psel);
        r.value = value;
        r.last = last;
        r.known = 1'b0;
        r.sum = '0;
        r.st = ST_OK;
        r.reg_idx = '0;
        r.reg_val = 0;
        return r;
    endfunction

    function automatic plan_row_t chk_row(op_t op, int cl, int col, int psel, int value,
            bit last, longint sum, status_t st);
        plan_row_t r;
        r = req_row(op, cl, col, psel, value, last);
        r.known = 1'b1;
        r.sum = SUM_WIDTH'(sum);
        r.st = st;
        return r;
    endfunction

    function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, int val);
        plan_row_t r;
        r = req_row(OP_READ, 0, 0, 0, 0, 1'b0);
        r.kind = STEP_CFG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    initial
    begin
        int use_cl;
        int use_col;
        int use_part;
        int sent;
        int pick;
        int near_zero;
        logic [CL_W-1:0] label;
        logic signed [VALUE_W-1:0] value;

        foreach (acc_store[i])
            acc_store[i] = '0;

        // Registers at their reset values, round robin at part zero.
        dir_plan.push_back(chk_row(OP_READ, 0, 0, 0, 0, 1'b0, 0, ST_OK));
        dir_plan.push_back(chk_row(OP_READ, 15, 63, 7, 0, 1'b0, 0, ST_OK));
        dir_plan.push_back(chk_row(OP_ACCUM, 0, 0, 0, 32'h7FFF_FFFF, 1'b0, 32'h7FFF_FFFF, ST_OK));
        dir_plan.push_back(chk_row(OP_ACCUM, 0, 0, 5, 32'h8000_0000, 1'b1, -1, ST_OK));
        dir_plan.push_back(chk_row(OP_ACCUM, 15, 63, 0, -1, 1'b1, -1, ST_OK));
        dir_plan.push_back(chk_row(OP_READ_ZERO, 0, 0, 0, 0, 1'b0, -1, ST_OK));
        dir_plan.push_back(chk_row(OP_READ, 0, 0, 0, 0, 1'b0, 0, ST_OK));
        dir_plan.push_back(chk_row(OP_READ_ALT, 15, 63, 1, 0, 1'b0, -1, ST_OK));
        dir_plan.push_back(chk_row(OP_READ, 15, 63, 1, 0, 1'b0, -1, ST_OK));
        dir_plan.push_back(cfg_row(REG_CLUSTERS, 4));
        dir_plan.push_back(chk_row(OP_ACCUM, 4, 0, 0, 5, 1'b1, 0, ST_BAD_LABEL));
        dir_plan.push_back(cfg_row(REG_COLUMNS, 8));
        dir_plan.push_back(chk_row(OP_READ, 4, 8, 0, 0, 1'b0, 0, ST_BAD_LABEL));
        dir_plan.push_back(chk_row(OP_READ, 3, 8, 0, 0, 1'b0, 0, ST_BAD_COLUMN));
        // Part two is now in use but beyond the lowered part count.
        dir_plan.push_back(cfg_row(REG_PARTS, 2));
        dir_plan.push_back(chk_row(OP_ACCUM, 0, 0, 0, 3, 1'b1, 0, ST_BAD_PART));
        dir_plan.push_back(chk_row(OP_READ, 0, 0, 2, 0, 1'b0, 0, ST_BAD_PART));
        dir_plan.push_back(chk_row(OP_READ, 3, 7, 1, 0, 1'b0, 0, ST_OK));
        dir_plan.push_back(cfg_row(REG_PARTS, 15));
        dir_plan.push_back(chk_row(OP_ACCUM, 3, 7, 0, 32'h0001_0000, 1'b1, 32'h0001_0000, ST_OK));
        dir_plan.push_back(cfg_row(REG_CLUSTERS, 127));
        dir_plan.push_back(cfg_row(REG_COLUMNS, 127));
        dir_plan.push_back(cfg_row(REG_SPARE, 0));
        dir_plan.push_back(chk_row(OP_READ, 15, 63, 7, 0, 1'b0, 0, ST_OK));
        dir_plan.push_back(req_row(OP_ACCUM, 15, 63, 3, 32'h1234_5678, 1'b0));
        dir_plan.push_back(cfg_row(REG_PARTS, 0));
        dir_plan.push_back(chk_row(OP_ACCUM, 0, 0, 0, 1, 1'b1, 0, ST_BAD_PART));
        dir_plan.push_back(cfg_row(REG_CLUSTERS, 0));
        dir_plan.push_back(chk_row(OP_READ, 0, 0, 0, 0, 1'b0, 0, ST_BAD_LABEL));
        dir_plan.push_back(cfg_row(REG_CLUSTERS, 16));
        dir_plan.push_back(cfg_row(REG_COLUMNS, 0));
        dir_plan.push_back(chk_row(OP_READ, 0, 0, 0, 0, 1'b0, 0, ST_BAD_COLUMN));
        dir_plan.push_back(cfg_row(REG_COLUMNS, 64));
        dir_plan.push_back(cfg_row(REG_PARTS, 8));
        dir_plan.push_back(req_row(OP_ACCUM, 1, 2, 0, -5, 1'b1));
        dir_plan.push_back(req_row(OP_READ, 15, 63, 3, 0, 1'b0));

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        idle_pct = 20;
        foreach (dir_plan[i])
        begin
            if (dir_plan[i].kind == STEP_CFG)
            begin
                wait_drained();
                write_reg(dir_plan[i].reg_idx, dir_plan[i].reg_val);
            end
            else
            begin
                req_known = dir_plan[i].known;
                req_sum = dir_plan[i].sum;
                req_status = dir_plan[i].st;
                send_request(dir_plan[i].op, dir_plan[i].cl, dir_plan[i].col,
                             dir_plan[i].psel, dir_plan[i].value, dir_plan[i].last);
            end
        end
        wait_drained();
        req_known = 1'b0;

        // Push one entry up by the largest positive step, clear it, then walk it down
        // by the largest negative step.
        idle_pct = 0;
        rewind_part();
        program_regs(1, 1, 1);
        for (int k = 0; k < RAIL_ADDS; k++)
            send_request(OP_ACCUM, '0, '0, '0, 32'sh7FFF_FFFF, 1'b1);
        send_request(OP_READ_ZERO, '0, '0, '0, '0, 1'b0);
        for (int k = 0; k < RAIL_ADDS; k++)
            send_request(OP_ACCUM, '0, '0, '0, 32'sh8000_0000, 1'b1);
        send_request(OP_ACCUM, '0, '0, '0, 32'sd1, 1'b0);

        for (int p = 0; p < PHASES; p++)
        begin
            if ($urandom_range(3, 0) != 0)
                rewind_part();
            case (p)
                0:       program_regs(16, 64, 8);
                1:       program_regs(1, 1, 1);
                5:       program_regs(7, 16, 3);
                default: program_regs(int'($urandom_range(16, 1)), int'($urandom_range(12, 1)),
                                      int'($urandom_range(8, 1)));
            endcase
            use_cl = capped(cfg_clusters, MAX_CLUSTERS);
            use_col = capped(cfg_columns, MAX_COLUMNS);
            use_part = capped(cfg_parts, MAX_PARTS);
            idle_pct = PHASE_IDLE[p];
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                pick = int'($urandom_range(99, 0));
                if (pick < 70)
                begin
                    // A whole row of one cluster, columns in order.
                    label = CL_W'($urandom_range(use_cl - 1, 0));
                    for (int c = 0; c < use_col; c++)
                    begin
                        near_zero = int'($urandom_range(2097152, 0)) - 1048576;
                        value = ($urandom_range(7, 0) == 0) ? VALUE_W'($urandom) : near_zero;
                        send_request(OP_ACCUM, label, COL_W'(c), PART_W'($urandom), value,
                                     c == use_col - 1);
                        sent++;
                    end
                end
                else if (pick < 85)
                begin
                    send_request(($urandom_range(1, 0) != 0) ? OP_READ : OP_READ_ZERO,
                                 CL_W'($urandom_range(use_cl - 1, 0)),
                                 COL_W'($urandom_range(use_col - 1, 0)),
                                 PART_W'($urandom_range(use_part - 1, 0)), '0, 1'b0);
                    sent++;
                end
                else
                begin
                    send_request(op_t'(OP_W'($urandom_range(3, 0))), CL_W'($urandom),
                                 COL_W'($urandom), PART_W'($urandom), VALUE_W'($urandom),
                                 1'($urandom));
                    sent++;
                end
            end
        end

        wait_drained();
        repeat (4) @(negedge clk);
        if (errors == 0)
            $display("kmeans_partial_centroid_sums_top_test: done, clean");
        else
            $display("kmeans_partial_centroid_sums_top_test: done, errors");
        $finish;
    end

endmodule
